/* rtl/kls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

  localparam int FRAC_BITS = 16;
  localparam int KC_W      = 5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] OUTCOME_FIRST  = 2'd0;
  localparam logic [1:0] OUTCOME_INTERP = 2'd1;
  localparam logic [1:0] OUTCOME_LAST   = 2'd2;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] t;
  } key_t;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [1:0]  outcome;
  } res_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS:0]   frac;
  } div_res_t;

endpackage

`default_nettype wire

/* rtl/kls_key_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module kls_key_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire kls_pkg::key_t   wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output kls_pkg::key_t        rd_data
);

  kls_pkg::key_t mem [DEPTH];
  kls_pkg::key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/kls_frac_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module kls_frac_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [31:0]         num,
  input  wire logic [31:0]         den,
  output kls_pkg::div_res_t        res
);

  localparam int CNT_W = $clog2(kls_pkg::FRAC_BITS + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [31:0]                 rem_r, rem_nxt;
  logic [31:0]                 den_r, den_nxt;
  logic [kls_pkg::FRAC_BITS:0] quo_r, quo_nxt;
  logic [32:0]                 shifted;
  logic [32:0]                 diff;
  logic                        ge;
  logic                        init_ge;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    ge       = (shifted >= {1'b0, den_r});
    init_ge  = (num >= den);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      den_nxt = den;
      if (den == 32'd0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = init_ge ? (num - den) : num;
        quo_nxt  = {{kls_pkg::FRAC_BITS{1'b0}}, init_ge};
        cnt_nxt  = CNT_W'(kls_pkg::FRAC_BITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : shifted[31:0];
      quo_nxt = {quo_r[kls_pkg::FRAC_BITS-1:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.frac = quo_r;

endmodule

`default_nettype wire

/* rtl/keyframe_linear_sampler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Linear keyframe sampler. Keys (time plus x/y/z, Q16.16) live in one synchronous
// table of MAX_KEYS entries; a write word is taken and gives no result. A sample
// word reads the table one key per cycle until it finds the first pair of keys that
// encloses the query time, then runs a one-bit-per-cycle divider for the Q1.16
// fraction and blends the three components through one shared multiplier, one
// component after another with a multiply step and an add step each. A sample
// either holds the first key, interpolates between an enclosing pair, or runs off
// the end and holds the last key in use. Table entries read before they were
// written return undefined data.
module keyframe_linear_sampler #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [4:0]    cfg_wr_data,   // key_count
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // key_index[3:0], key_time[35:4], key_x[67:36], key_y[99:68], key_z[131:100],
  // query_time[163:132], zero pad
  input  wire logic [167:0]  in_tdata,
  input  wire logic          in_tuser,      // op
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [95:0]        out_tdata,     // out_x, out_y, out_z
  output logic [1:0]         out_tuser      // outcome
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = ($clog2(MAX_KEYS + 1) > kls_pkg::KC_W) ?
                      $clog2(MAX_KEYS + 1) : kls_pkg::KC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [kls_pkg::KC_W-1:0]    kc_r;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [31:0]                 q_r, q_nxt;
  kls_pkg::key_t               prev_r, prev_nxt;
  kls_pkg::key_t               cur_r, cur_nxt;
  logic [kls_pkg::FRAC_BITS:0] frac_r, frac_nxt;
  logic [1:0]                  comp_r, comp_nxt;
  logic [47:0]                 p_r, p_nxt;
  kls_pkg::res_t               res_r, res_nxt;
  kls_pkg::res_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        in_accept;
  logic [3:0]                  in_key_index;
  kls_pkg::key_t               wr_key;
  logic                        wr_en;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  kls_pkg::key_t               rd_data;
  logic                        div_start;
  logic [31:0]                 div_num;
  logic [31:0]                 div_den;
  kls_pkg::div_res_t           div_res;
  logic [CW-1:0]               kc_ext;
  logic [CW-1:0]               n_keys;
  logic [CW-1:0]               n_last;
  logic [31:0]                 comp_a;
  logic [31:0]                 comp_b;
  logic signed [32:0]          diff;
  logic signed [17:0]          frac_s;
  logic signed [50:0]          prod;
  logic [31:0]                 blend_sum;

  assign in_tready    = (state_r == S_IDLE);
  assign in_accept    = in_tvalid && in_tready;
  assign in_key_index = in_tdata[3:0];
  assign wr_key.t     = in_tdata[35:4];
  assign wr_key.x     = in_tdata[67:36];
  assign wr_key.y     = in_tdata[99:68];
  assign wr_key.z     = in_tdata[131:100];
  assign wr_en        = in_accept && (in_tuser == kls_pkg::OP_WRITE) &&
                        (32'(in_key_index) < MAX_KEYS);

  assign kc_ext = CW'(kc_r);
  always_comb begin
    if (kc_ext == '0) begin
      n_keys = CW'(1);
    end else if (kc_ext > CW'(MAX_KEYS)) begin
      n_keys = CW'(MAX_KEYS);
    end else begin
      n_keys = kc_ext;
    end
    n_last = n_keys - CW'(1);
  end

  kls_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_key_index)),
    .wr_data (wr_key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kls_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  always_comb begin
    unique case (comp_r)
      2'd0: begin
        comp_a = prev_r.x;
        comp_b = cur_r.x;
      end
      2'd1: begin
        comp_a = prev_r.y;
        comp_b = cur_r.y;
      end
      default: begin
        comp_a = prev_r.z;
        comp_b = cur_r.z;
      end
    endcase
    diff      = $signed({comp_b[31], comp_b}) - $signed({comp_a[31], comp_a});
    frac_s    = $signed({1'b0, frac_r});
    prod      = diff * frac_s;
    blend_sum = comp_a + p_r[47:16];
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    frac_nxt      = frac_r;
    comp_nxt      = comp_r;
    p_nxt         = p_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    div_start     = 1'b0;
    div_num       = q_r - prev_r.t;
    div_den       = rd_data.t - prev_r.t;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_tuser == kls_pkg::OP_SAMPLE)) begin
          q_nxt     = in_tdata[163:132];
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        prev_nxt = rd_data;
        if ((n_last == '0) || (q_r <= rd_data.t)) begin
          res_nxt.x       = rd_data.x;
          res_nxt.y       = rd_data.y;
          res_nxt.z       = rd_data.z;
          res_nxt.outcome = kls_pkg::OUTCOME_FIRST;
          state_nxt       = S_OUT;
        end else begin
          idx_nxt   = AW'(1);
          rd_en     = 1'b1;
          rd_addr   = AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((prev_r.t <= q_r) && (q_r <= rd_data.t)) begin
          cur_nxt   = rd_data;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (CW'(idx_r) == n_last) begin
          res_nxt.x       = rd_data.x;
          res_nxt.y       = rd_data.y;
          res_nxt.z       = rd_data.z;
          res_nxt.outcome = kls_pkg::OUTCOME_LAST;
          state_nxt       = S_OUT;
        end else begin
          prev_nxt = rd_data;
          idx_nxt  = idx_r + AW'(1);
          rd_en    = 1'b1;
          rd_addr  = idx_r + AW'(1);
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          frac_nxt  = div_res.frac;
          comp_nxt  = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        p_nxt     = 48'(prod);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        unique case (comp_r)
          2'd0:    res_nxt.x = blend_sum;
          2'd1:    res_nxt.y = blend_sum;
          default: res_nxt.z = blend_sum;
        endcase
        if (comp_r == 2'd2) begin
          res_nxt.outcome = kls_pkg::OUTCOME_INTERP;
          state_nxt       = S_OUT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kc_r        <= kls_pkg::KC_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        kc_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    q_r    <= q_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    frac_r <= frac_nxt;
    comp_r <= comp_nxt;
    p_r    <= p_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.z, out_r.y, out_r.x};
  assign out_tuser  = out_r.outcome;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(idx_r) <= n_last) && (idx_r != '0))
    else $error("scan index outside the keys in use");

  a_sample_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tuser == kls_pkg::OP_SAMPLE)) |=> (state_r == S_FIRST))
    else $error("sample word did not start a table read");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (div_res.frac <= (kls_pkg::FRAC_BITS + 1)'(1 << kls_pkg::FRAC_BITS)))
    else $error("fraction above one");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == kls_pkg::OUTCOME_FIRST) ||
                   (out_tuser == kls_pkg::OUTCOME_INTERP) ||
                   (out_tuser == kls_pkg::OUTCOME_LAST))
    else $error("result word with an unknown outcome");
`endif

endmodule

`default_nettype wire

/* sim/tb_keyframe_linear_sampler.sv */
`timescale 1ns / 1ps

module tb_keyframe_linear_sampler;

  typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_SETUP} row_kind_t;

  typedef struct {
    logic        op;
    logic [3:0]  slot;
    logic [31:0] t, x, y, z, q;
  } sampler_word_t;

  // sample rows reuse x/y/z as the typed result; setup rows carry key_count in q
  typedef struct {
    row_kind_t   kind;
    logic [3:0]  slot;
    logic [31:0] t, x, y, z, q;
    bit          has_exp;
    logic [1:0]  outcome;
  } script_row_t;

  script_row_t script [18] = '{
    '{ROW_WRITE,  0, 'h10000, 'h7fffffff, 'h80000000, 0, 0, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 'h7fffffff, 'h80000000, 0, 0, 1, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 'h7fffffff, 'h80000000, 0, 'hffffffff, 1, kls_pkg::OUTCOME_FIRST},
    '{ROW_WRITE,  1, 'h30000, 'h80000000, 'h7fffffff, 'hffffffff, 0, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_WRITE,  2, 'h20000, 1, 'hffffffff, 5, 0, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_WRITE,  3, 'hffffffff, 0, 0, 'h12345678, 0, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_WRITE,  15, 0, 'h5a5a5a5a, 'ha5a5a5a5, 'h0f0f0f0f, 0, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SETUP,  0, 0, 0, 0, 0, 2, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 'h7fffffff, 'h80000000, 0, 'h10000, 1, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 'h20000, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 'h80000000, 'h7fffffff, 'hffffffff, 'h30000, 1, kls_pkg::OUTCOME_INTERP},
    '{ROW_SAMPLE, 0, 0, 'h80000000, 'h7fffffff, 'hffffffff, 'h30001, 1, kls_pkg::OUTCOME_LAST},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 'h10001, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SETUP,  0, 0, 0, 0, 0, 4, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 'h28000, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 0, 0, 'h12345678, 'hffffffff, 1, kls_pkg::OUTCOME_INTERP},
    '{ROW_SETUP,  0, 0, 0, 0, 0, 0, 0, kls_pkg::OUTCOME_FIRST},
    '{ROW_SAMPLE, 0, 0, 'h7fffffff, 'h80000000, 0, 'hffffffff, 1, kls_pkg::OUTCOME_FIRST}
  };

  int kc_plan [12] = '{16, 1, 2, 0, 31, 5, 16, 9, 3, 16, 12, 7};
  localparam int WORDS_PER_PHASE = 94;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [4:0]   cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  // shadow of the key table and key_count
  logic [31:0] t_tab [16];
  logic [31:0] x_tab [16];
  logic [31:0] y_tab [16];
  logic [31:0] z_tab [16];
  logic [4:0]  key_count_reg = 5'd1;

  kls_pkg::res_t pending_samples [$];
  int   errors = 0;
  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   n_writes = 0;
  int   n_samples = 0;
  int   n_settings = 0;
  int   seen_outcome [3] = '{0, 0, 0};

  keyframe_linear_sampler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int keys_in_use();
    if (key_count_reg == 0) return 1;
    if (key_count_reg > 16) return 16;
    return key_count_reg;
  endfunction

  function automatic logic [31:0] blend_component(logic [31:0] a, logic [31:0] b,
                                                  logic [16:0] frac);
    longint delta;
    longint prod;
    delta = longint'($signed(b)) - longint'($signed(a));
    prod = delta * longint'(frac);
    // arithmetic shift floors toward minus infinity
    return 32'(longint'($signed(a)) + (prod >>> 16));
  endfunction

  function automatic kls_pkg::res_t predict_sample(logic [31:0] q);
    int            n;
    logic [31:0]   t0, t1, span;
    logic [16:0]   frac;
    kls_pkg::res_t r;
    n = keys_in_use();
    r.x = x_tab[0];
    r.y = y_tab[0];
    r.z = z_tab[0];
    r.outcome = kls_pkg::OUTCOME_FIRST;
    if (n == 1 || q <= t_tab[0]) return r;
    for (int i = 0; i + 1 < n; i++) begin
      t0 = t_tab[i];
      t1 = t_tab[i + 1];
      if (t0 <= q && q <= t1) begin
        span = t1 - t0;
        frac = (span == 0) ? 17'd0 : 17'(({32'd0, q - t0} << 16) / {32'd0, span});
        r.x = blend_component(x_tab[i], x_tab[i + 1], frac);
        r.y = blend_component(y_tab[i], y_tab[i + 1], frac);
        r.z = blend_component(z_tab[i], z_tab[i + 1], frac);
        r.outcome = kls_pkg::OUTCOME_INTERP;
        return r;
      end
    end
    r.x = x_tab[n - 1];
    r.y = y_tab[n - 1];
    r.z = z_tab[n - 1];
    r.outcome = kls_pkg::OUTCOME_LAST;
    return r;
  endfunction

  function automatic sampler_word_t rand_word();
    sampler_word_t w;
    w.op = 1'($urandom_range(1));
    w.slot = 4'($urandom_range(15));
    w.t = $urandom;
    w.x = $urandom;
    w.y = $urandom;
    w.z = $urandom;
    w.q = $urandom;
    return w;
  endfunction

  // starts and ends on a falling edge
  task automatic send_word(input sampler_word_t w, input bit use_typed,
                           input kls_pkg::res_t typed);
    kls_pkg::res_t exp_word;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.op;
    in_tdata <= {4'b0, w.q, w.z, w.y, w.x, w.t, w.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (w.op == kls_pkg::OP_WRITE) begin
      t_tab[w.slot] = w.t;
      x_tab[w.slot] = w.x;
      y_tab[w.slot] = w.y;
      z_tab[w.slot] = w.z;
      n_writes++;
    end else begin
      exp_word = use_typed ? typed : predict_sample(w.q);
      pending_samples.insert(pending_samples.size(), exp_word);
      n_samples++;
    end
    @(negedge clk);
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_key_count(input logic [4:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    key_count_reg = v;
    n_settings++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        $error("result word with nothing expected: %h / %h", out_tdata, out_tuser);
        errors++;
      end else begin
        kls_pkg::res_t want;
        want = pending_samples.pop_front();
        check_field("out_x", want.x, out_tdata[31:0]);
        check_field("out_y", want.y, out_tdata[63:32]);
        check_field("out_z", want.z, out_tdata[95:64]);
        check_field("outcome", 32'(want.outcome), 32'(out_tuser));
      end
      if (out_tuser <= kls_pkg::OUTCOME_LAST) seen_outcome[out_tuser]++;
    end
  end

  initial begin
    sampler_word_t w;
    kls_pkg::res_t typed;
    int            n;
    int            pick;
    logic [31:0]   stamp;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_SETUP) begin
        drain(8);
        set_key_count(script[r].q[4:0]);
      end else begin
        w = rand_word();
        if (script[r].kind == ROW_WRITE) begin
          w.op = kls_pkg::OP_WRITE;
          w.slot = script[r].slot;
          w.t = script[r].t;
          w.x = script[r].x;
          w.y = script[r].y;
          w.z = script[r].z;
        end else begin
          w.op = kls_pkg::OP_SAMPLE;
          w.q = script[r].q;
        end
        typed.x = script[r].x;
        typed.y = script[r].y;
        typed.z = script[r].z;
        typed.outcome = script[r].outcome;
        send_word(w, script[r].has_exp, typed);
      end
    end

    foreach (kc_plan[p]) begin
      drain(8);
      set_key_count(kc_plan[p][4:0]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      n = keys_in_use();

      // load a rising table first so samples reach every pair
      stamp = $urandom_range(32'hbfff_ffff, 0);
      for (int s = 0; s < n; s++) begin
        w = rand_word();
        w.op = kls_pkg::OP_WRITE;
        w.slot = 4'(s);
        w.t = stamp;
        send_word(w, 1'b0, '0);
        stamp += $urandom_range(1 << $urandom_range(26, 0), 0);
      end

      for (int k = n; k < WORDS_PER_PHASE; k++) begin
        if (k == WORDS_PER_PHASE / 2) drain(0);
        w = rand_word();
        pick = $urandom_range(99);
        if (pick < 10) begin
          w.op = kls_pkg::OP_WRITE;
          if (pick >= 4) w.t = $urandom_range(t_tab[n - 1], t_tab[0]);
        end else begin
          w.op = kls_pkg::OP_SAMPLE;
          if (pick < 35) w.q = t_tab[$urandom_range(n - 1, 0)];
          else if (pick < 85) w.q = $urandom_range(t_tab[n - 1], t_tab[0]);
          else if (pick < 93) w.q = t_tab[0] - $urandom_range(3, 0);
        end
        send_word(w, 1'b0, '0);
      end
    end

    sender_idle_pct = 0;
    drain(20);
    if (pending_samples.size() != 0) begin
      $error("%0d results never arrived", pending_samples.size());
      errors++;
    end
    $display("covered %0d key writes and %0d samples over %0d key_count settings",
             n_writes, n_samples, n_settings);
    $display("results held first %0d, interpolated %0d, held last %0d",
             seen_outcome[0], seen_outcome[1], seen_outcome[2]);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
